// ----- src/ktk_pkg.sv -----
// Package for the keyed top-k table: field widths, mode and status codes, defaults.
// No dependencies; the interfaces and the core import it.
`timescale 1ns / 1ps

package ktk_pkg;

   localparam int MODE_W   = 2;
   localparam int KEY_W    = 32;
   localparam int VALUE_W  = 32;
   localparam int K_W      = 5;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;
   localparam int LIVE_W   = 5;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int MAX_RESULTS     = 16;

   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STAT_ADDED   = 3'd0,
      STAT_REMOVED = 3'd1,
      STAT_NOOP    = 3'd2,
      STAT_FULL    = 3'd3,
      STAT_ENTRY   = 3'd4
   } status_type;

endpackage

// ----- src/ktk_if.sv -----
// Valid/ready channel interfaces for the keyed top-k table: request and response beats.
// Depends on ktk_pkg for the field widths and the status type.
`timescale 1ns / 1ps

interface ktk_req_if import ktk_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic [KEY_W-1:0]          key;
   logic signed [VALUE_W-1:0] value;
   logic [K_W-1:0]            k_count;

   modport source (output valid, mode, key, value, k_count, input ready);
   modport sink   (input valid, mode, key, value, k_count, output ready);
endinterface

interface ktk_rsp_if import ktk_pkg::*; ();
   logic                      valid;
   logic                      ready;
   status_type                status;
   logic signed [VALUE_W-1:0] entry_value;
   logic [SLOT_W-1:0]         entry_slot;
   logic [LIVE_W-1:0]         live_count;
   logic                      last;

   modport source (output valid, status, entry_value, entry_slot, live_count, last,
                   input ready);
   modport sink   (input valid, status, entry_value, entry_slot, live_count, last,
                   output ready);
endinterface

// ----- src/keyed_table_top_k_select_core.sv -----
// Keyed top-k table core: slot memories, live marks and the scan sequencer.
// Depends on ktk_pkg and the channel interfaces in ktk_if.sv.
`timescale 1ns / 1ps

// The block takes one request beat at a time and is not ready until that request has
// produced all of its response beats. Every step walks the allocated slots (A of them)
// through one registered read port of the key and value memories and one 32-bit
// comparator. An add or remove is accepted, reads the allocated slots in turn, waits
// on the read register and closes the pass, then takes an update step that also loads
// the response; a lookup hit ends the pass early and an empty table skips the reads.
// A query emits each of its beats after a full pass over the slots; a query with
// nothing to emit, or an unused mode, answers with a single no-op beat and no pass.
// Response stalls hold the update and emit steps until the response register is free.
// Live marks reset at once; slot keys and values need no clearing pass.
module keyed_table_top_k_select_core
   import ktk_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ktk_req_if.sink   req_ch,
   ktk_rsp_if.source rsp_ch
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int NW = (CW > K_W) ? CW : K_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_RESOLVE,
      ST_NOOP,
      ST_SCAN,
      ST_PUT
   } state_type;

   // control
   state_type                 state_ff, state_in;
   logic [CW-1:0]             scan_ff, scan_in;
   logic                      pvld_ff, pvld_in;
   logic [IW-1:0]             pidx_ff, pidx_in;
   logic [CW-1:0]             alloc_ff, alloc_in;
   logic [CW-1:0]             live_ff, live_in;
   logic [TABLE_DEPTH-1:0]    live_bits_ff, live_bits_in;
   logic [TABLE_DEPTH-1:0]    taken_ff, taken_in;
   logic                      hit_vld_ff, hit_vld_in;
   logic [IW-1:0]             hit_slot_ff, hit_slot_in;
   logic                      best_vld_ff, best_vld_in;
   logic signed [VALUE_W-1:0] best_val_ff, best_val_in;
   logic [IW-1:0]             best_slot_ff, best_slot_in;
   logic [K_W-1:0]            n_ff, n_in;
   logic [K_W-1:0]            e_ff, e_in;

   // latched request
   logic [MODE_W-1:0]         mode_ff, mode_in;
   logic [KEY_W-1:0]          key_ff, key_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [SLOT_W-1:0]         rsp_slot_ff, rsp_slot_in;
   logic [LIVE_W-1:0]         rsp_live_ff, rsp_live_in;
   logic                      rsp_last_ff, rsp_last_in;

   // slot memories
   logic [KEY_W-1:0]          key_mem [TABLE_DEPTH];
   logic signed [VALUE_W-1:0] val_mem [TABLE_DEPTH];
   logic [KEY_W-1:0]          rd_key_ff;
   logic signed [VALUE_W-1:0] rd_val_ff;
   logic [IW-1:0]             rd_addr;
   logic [IW-1:0]             wr_addr;
   logic                      key_we;
   logic                      val_we;

   logic                      out_free;
   logic                      issue;
   logic                      match;
   logic                      cand;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign issue    = ((state_ff == ST_FIND) || (state_ff == ST_SCAN)) && (scan_ff < alloc_ff);
   assign match    = pvld_ff && (rd_key_ff == key_ff);
   assign cand     = pvld_ff && live_bits_ff[pidx_ff] && !taken_ff[pidx_ff];
   assign rd_addr  = scan_ff[IW-1:0];

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_value = rsp_value_ff;
   assign rsp_ch.entry_slot  = rsp_slot_ff;
   assign rsp_ch.live_count  = rsp_live_ff;
   assign rsp_ch.last        = rsp_last_ff;

   always_comb begin
      logic [NW-1:0] n_full;

      state_in      = state_ff;
      scan_in       = scan_ff;
      pvld_in       = issue;
      pidx_in       = scan_ff[IW-1:0];
      alloc_in      = alloc_ff;
      live_in       = live_ff;
      live_bits_in  = live_bits_ff;
      taken_in      = taken_ff;
      hit_vld_in    = hit_vld_ff;
      hit_slot_in   = hit_slot_ff;
      best_vld_in   = best_vld_ff;
      best_val_in   = best_val_ff;
      best_slot_in  = best_slot_ff;
      n_in          = n_ff;
      e_in          = e_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_live_in   = rsp_live_ff;
      rsp_last_in   = rsp_last_ff;
      wr_addr       = hit_slot_ff;
      key_we        = 1'b0;
      val_we        = 1'b0;
      n_full        = NW'(req_ch.k_count);

      if (issue) begin
         scan_in = scan_ff + CW'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               mode_in    = req_ch.mode;
               key_in     = req_ch.key;
               value_in   = req_ch.value;
               scan_in    = '0;
               hit_vld_in = 1'b0;
               if (NW'(live_ff) < n_full) begin
                  n_full = NW'(live_ff);
               end
               if (NW'(MAX_RESULTS) < n_full) begin
                  n_full = NW'(MAX_RESULTS);
               end
               case (req_ch.mode)
                  MODE_ADD, MODE_REMOVE: begin
                     state_in = ST_FIND;
                  end
                  MODE_QUERY: begin
                     n_in        = K_W'(n_full);
                     e_in        = '0;
                     taken_in    = '0;
                     best_vld_in = 1'b0;
                     state_in    = (n_full == '0) ? ST_NOOP : ST_SCAN;
                  end
                  default: begin
                     state_in = ST_NOOP;
                  end
               endcase
            end
         end

         ST_FIND: begin
            if (match) begin
               hit_vld_in  = 1'b1;
               hit_slot_in = pidx_ff;
               state_in    = ST_RESOLVE;
            end else if (!pvld_ff && (scan_ff == alloc_ff)) begin
               state_in = ST_RESOLVE;
            end
         end

         ST_RESOLVE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_slot_in   = '0;
               rsp_status_in = STAT_NOOP;
               if (mode_ff == MODE_ADD) begin
                  if (hit_vld_ff) begin
                     val_we        = 1'b1;
                     rsp_status_in = STAT_ADDED;
                     rsp_slot_in   = SLOT_W'(hit_slot_ff);
                     if (!live_bits_ff[hit_slot_ff]) begin
                        live_bits_in[hit_slot_ff] = 1'b1;
                        live_in = live_ff + CW'(1);
                     end
                  end else if (alloc_ff == CW'(TABLE_DEPTH)) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     // fresh slot at the allocation mark
                     wr_addr                         = alloc_ff[IW-1:0];
                     key_we                          = 1'b1;
                     val_we                          = 1'b1;
                     live_bits_in[alloc_ff[IW-1:0]]  = 1'b1;
                     live_in                         = live_ff + CW'(1);
                     alloc_in                        = alloc_ff + CW'(1);
                     rsp_status_in                   = STAT_ADDED;
                     rsp_slot_in                     = SLOT_W'(alloc_ff[IW-1:0]);
                  end
               end else if (hit_vld_ff && live_bits_ff[hit_slot_ff]) begin
                  live_bits_in[hit_slot_ff] = 1'b0;
                  live_in                   = live_ff - CW'(1);
                  rsp_status_in             = STAT_REMOVED;
                  rsp_slot_in               = SLOT_W'(hit_slot_ff);
               end
               rsp_live_in = LIVE_W'(live_in);
               state_in    = ST_IDLE;
            end
         end

         ST_NOOP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_NOOP;
               rsp_value_in  = '0;
               rsp_slot_in   = '0;
               rsp_live_in   = LIVE_W'(live_ff);
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_SCAN: begin
            // strict greater keeps the lower slot on ties
            if (cand && (!best_vld_ff || (rd_val_ff > best_val_ff))) begin
               best_vld_in  = 1'b1;
               best_val_in  = rd_val_ff;
               best_slot_in = pidx_ff;
            end
            if (!pvld_ff && (scan_ff == alloc_ff)) begin
               state_in = ST_PUT;
            end
         end

         ST_PUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_live_in  = LIVE_W'(live_ff);
               if (best_vld_ff) begin
                  rsp_status_in          = STAT_ENTRY;
                  rsp_value_in           = best_val_ff;
                  rsp_slot_in            = SLOT_W'(best_slot_ff);
                  rsp_last_in            = (K_W'(e_ff + K_W'(1)) == n_ff);
                  taken_in[best_slot_ff] = 1'b1;
                  e_in                   = e_ff + K_W'(1);
                  if (K_W'(e_ff + K_W'(1)) == n_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     scan_in     = '0;
                     best_vld_in = 1'b0;
                     state_in    = ST_SCAN;
                  end
               end else begin
                  // live marks ran out early: close the query
                  rsp_status_in = STAT_NOOP;
                  rsp_value_in  = '0;
                  rsp_slot_in   = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pvld_ff      <= 1'b0;
         alloc_ff     <= '0;
         live_ff      <= '0;
         live_bits_ff <= '0;
         best_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pvld_ff      <= pvld_in;
         alloc_ff     <= alloc_in;
         live_ff      <= live_in;
         live_bits_ff <= live_bits_in;
         best_vld_ff  <= best_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff       <= scan_in;
      pidx_ff       <= pidx_in;
      taken_ff      <= taken_in;
      hit_vld_ff    <= hit_vld_in;
      hit_slot_ff   <= hit_slot_in;
      best_val_ff   <= best_val_in;
      best_slot_ff  <= best_slot_in;
      n_ff          <= n_in;
      e_ff          <= e_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_live_ff   <= rsp_live_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= key_ff;
      end
      if (val_we) begin
         val_mem[wr_addr] <= value_ff;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_val_ff <= val_mem[rd_addr];
   end

   a_live_count: assert property (@(posedge clock) disable iff (reset)
      $countones(live_bits_ff) == int'(live_ff))
      else $error("live count does not match live marks");

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      (live_ff <= alloc_ff) && (alloc_ff <= CW'(TABLE_DEPTH)))
      else $error("live or allocated count out of range");

   a_hit_allocated: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIND) && match |-> (CW'(pidx_ff) < alloc_ff))
      else $error("key lookup hit beyond the allocation mark");

   a_taken_marked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT) && out_free && best_vld_ff |=> taken_ff[$past(best_slot_ff)])
      else $error("emitted slot not marked taken");

endmodule

// ----- verif/ktk_table_checker.sv -----
// Checker for the keyed top-k table: watches the request and response channels,
// predicts every response beat and compares. Depends on ktk_pkg and ktk_if.sv.
`timescale 1ns / 1ps

module ktk_table_checker
   import ktk_pkg::*;
#(
   parameter int DEPTH = TABLE_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   ktk_req_if   req_mon,
   ktk_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_beats
);

   typedef struct packed {
      status_type          status;
      logic [VALUE_W-1:0]  value;
      logic [SLOT_W-1:0]   slot;
      logic [LIVE_W-1:0]   live;
      logic                last;
   } table_beat_type;

   logic [KEY_W-1:0]          slot_key [DEPTH];
   logic signed [VALUE_W-1:0] slot_val [DEPTH];
   logic [DEPTH-1:0]          slot_live;
   int                        slots_used;
   int                        live_slots;
   int                        errors = 0;
   table_beat_type            expected_beats [$];
   table_beat_type            want;

   function automatic void push_beat(status_type st, logic [VALUE_W-1:0] v, int slot,
                                     logic last_flag);
      table_beat_type b;
      b.status = st;
      b.value  = v;
      b.slot   = slot[SLOT_W-1:0];
      b.live   = live_slots[LIVE_W-1:0];
      b.last   = last_flag;
      expected_beats.push_back(b);
   endfunction

   function automatic void predict_table_step(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                              logic signed [VALUE_W-1:0] value,
                                              logic [K_W-1:0] k_count);
      int hit;
      int n;
      int best;
      int e;
      int i;
      logic [DEPTH-1:0] taken;
      hit = -1;
      for (i = 0; i < slots_used; i++)
         if (hit < 0 && slot_key[i] == key) hit = i;
      case (mode)
         MODE_ADD: begin
            if (hit < 0 && slots_used >= DEPTH) begin
               push_beat(STAT_FULL, '0, 0, 1'b1);
            end else begin
               if (hit < 0) begin
                  hit = slots_used;
                  slots_used++;
                  slot_key[hit] = key;
               end
               slot_val[hit] = value;
               if (!slot_live[hit]) begin
                  slot_live[hit] = 1'b1;
                  live_slots++;
               end
               push_beat(STAT_ADDED, '0, hit, 1'b1);
            end
         end
         MODE_REMOVE: begin
            if (hit < 0 || !slot_live[hit]) begin
               push_beat(STAT_NOOP, '0, 0, 1'b1);
            end else begin
               slot_live[hit] = 1'b0;
               live_slots--;
               push_beat(STAT_REMOVED, '0, hit, 1'b1);
            end
         end
         MODE_QUERY: begin
            n = k_count;
            if (n > live_slots) n = live_slots;
            if (n > MAX_RESULTS) n = MAX_RESULTS;
            if (n == 0) push_beat(STAT_NOOP, '0, 0, 1'b1);
            taken = '0;
            // selection pass per beat; strict compare keeps the lower slot on ties
            for (e = 0; e < n; e++) begin
               best = -1;
               for (i = 0; i < slots_used; i++)
                  if (slot_live[i] && !taken[i] && (best < 0 || slot_val[i] > slot_val[best]))
                     best = i;
               taken[best] = 1'b1;
               push_beat(STAT_ENTRY, slot_val[best], best, e == n - 1);
            end
         end
         default: push_beat(STAT_NOOP, '0, 0, 1'b1);
      endcase
   endfunction

   task automatic check_field(string name, logic [31:0] wanted, logic [31:0] seen);
      if (seen !== wanted) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, wanted, seen);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         slot_live  = '0;
         slots_used = 0;
         live_slots = 0;
         expected_beats.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_table_step(req_mon.mode, req_mon.key, req_mon.value, req_mon.k_count);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_beats.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat, expected none, actual status %0d value %h",
                        $time, rsp_mon.status, rsp_mon.entry_value);
            end else begin
               want = expected_beats.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_mon.status));
               check_field("entry_value", want.value, rsp_mon.entry_value);
               check_field("entry_slot", 32'(want.slot), 32'(rsp_mon.entry_slot));
               check_field("live_count", 32'(want.live), 32'(rsp_mon.live_count));
               check_field("last", 32'(want.last), 32'(rsp_mon.last));
            end
         end
      end
      fail_count    <= errors;
      pending_beats <= expected_beats.size();
   end

endmodule

// ----- verif/testbench.sv -----
// Top of the keyed top-k table testbench: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on ktk_pkg, ktk_if.sv, the core and the checker.
`timescale 1ns / 1ps

module testbench;
   import ktk_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS     = 448;
   localparam int CALM_ITEMS       = 60;
   localparam int LONG_HOLD_AT     = 50;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES      = 300;
   localparam int CYCLE_LIMIT      = 1_000_000;

   logic clock = 1'b0;
   logic reset;
   int   sent_count;
   bit   calm;
   bit   hold_done = 1'b0;
   int   fail_count;
   int   pending_beats;
   int   cycles = 0;
   logic [KEY_W-1:0] key_pool [$];

   ktk_req_if req_ch ();
   ktk_rsp_if rsp_ch ();

   keyed_table_top_k_select_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ktk_table_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_beats (pending_beats)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("testbench NOT OK");
      $finish;
   end

   // extremes and small values show up often so that ties get exercised
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       pick_value = 32'sh8000_0000;
         1:       pick_value = 32'sh7FFF_FFFF;
         2, 3:    pick_value = $urandom_range(0, 3) - 1;
         default: pick_value = $urandom;
      endcase
   endfunction

   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                            input logic signed [VALUE_W-1:0] value,
                            input logic [K_W-1:0] k_count);
      req_ch.valid   <= 1'b1;
      req_ch.mode    <= mode;
      req_ch.key     <= key;
      req_ch.value   <= value;
      req_ch.k_count <= k_count;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count <= sent_count + 1;
   endtask

   task automatic idle_sender(input int n);
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
   endtask

   // response side: random stall bursts, one long hold-off, none once calm
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && sent_count >= LONG_HOLD_AT) begin
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin
      logic [KEY_W-1:0] fresh;
      logic [KEY_W-1:0] pick_key;
      bit               gappy;
      int               i;
      int               r;
      req_ch.valid   <= 1'b0;
      req_ch.mode    <= MODE_ADD;
      req_ch.key     <= '0;
      req_ch.value   <= '0;
      req_ch.k_count <= '0;
      sent_count     <= 0;
      calm           <= 1'b0;
      gappy          = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // directed: empty table, unknown remove, unused mode
      send_item(MODE_QUERY, 32'h0000_1234, 32'sd0, 5'd16);
      send_item(MODE_REMOVE, 32'h0000_1234, 32'sd0, 5'd0);
      send_item(MODE_UNUSED, $urandom, $urandom, 5'd31);
      // query with no live entry after an add and remove
      send_item(MODE_ADD, 32'h0000_0000, 32'sh8000_0000, 5'd0);
      send_item(MODE_REMOVE, 32'h0000_0000, 32'sd0, 5'd0);
      send_item(MODE_QUERY, 32'h0000_0000, 32'sd0, 5'd3);
      send_item(MODE_ADD, 32'h0000_0000, 32'sh8000_0000, 5'd0);
      send_item(MODE_ADD, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 5'd31);
      send_item(MODE_ADD, 32'hA5A5_5A5A, 32'sd0, 5'd0);
      send_item(MODE_ADD, 32'h5A5A_A5A5, -32'sd1, 5'd0);
      send_item(MODE_ADD, 32'h0F0F_F0F0, 32'sd0, 5'd0);
      send_item(MODE_ADD, 32'hFFFF_FFFF, -32'sd1, 5'd0);
      send_item(MODE_REMOVE, 32'hA5A5_5A5A, 32'sd0, 5'd0);
      send_item(MODE_REMOVE, 32'hA5A5_5A5A, 32'sd0, 5'd0);
      send_item(MODE_QUERY, 32'h0000_0000, 32'sd0, 5'd0);
      send_item(MODE_QUERY, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 5'd31);
      send_item(MODE_ADD, 32'hA5A5_5A5A, 32'sd5, 5'd0);
      send_item(MODE_QUERY, 32'h0000_0000, 32'sd0, 5'd1);
      key_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'h5A5A_A5A5,
                   32'h0F0F_F0F0};
      // fill the rest, then hit the full table
      for (i = 0; i < TABLE_DEPTH_DEF - 5; i++) begin
         fresh = $urandom;
         key_pool.push_back(fresh);
         send_item(MODE_ADD, fresh, pick_value(), K_W'($urandom_range(0, 31)));
      end
      send_item(MODE_ADD, 32'hDEAD_0001, 32'sd7, 5'd0);
      send_item(MODE_QUERY, 32'h0000_0000, 32'sd0, 5'd16);
      send_item(MODE_REMOVE, 32'hDEAD_0002, 32'sd0, 5'd0);
      wait_drained();

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 32 == 0) gappy = $urandom_range(0, 2) != 0;
         if (i == RANDOM_ITEMS / 2) wait_drained();
         if (i == RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
         if (gappy && i < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 2) == 0)
            idle_sender($urandom_range(1, 11));
         pick_key = key_pool[$urandom_range(0, key_pool.size() - 1)];
         r = $urandom_range(0, 99);
         if (r < 35)
            send_item(MODE_ADD, pick_key, pick_value(), K_W'($urandom_range(0, 31)));
         else if (r < 60)
            send_item(MODE_REMOVE, pick_key, $urandom, K_W'($urandom_range(0, 31)));
         else if (r < 70)
            send_item(MODE_ADD, $urandom, pick_value(), K_W'($urandom_range(0, 31)));
         else if (r < 75)
            send_item(MODE_REMOVE, $urandom, $urandom, K_W'($urandom_range(0, 31)));
         else if (r < 90)
            send_item(MODE_QUERY, $urandom, $urandom, K_W'($urandom_range(0, 6)));
         else if (r < 97)
            send_item(MODE_QUERY, $urandom, $urandom, K_W'($urandom_range(0, 31)));
         else
            send_item(MODE_UNUSED, $urandom, $urandom, K_W'($urandom_range(0, 31)));
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_beats == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/ktk_pkg.sv
src/ktk_if.sv
src/keyed_table_top_k_select_core.sv
verif/ktk_table_checker.sv
verif/testbench.sv
